### sv/nsp_pkg.sv
// Shared types, constants and a helper function for the note sequence player.
// Depends on nothing; nsp_cfg, nsp_core and the top level import it.
package nsp_pkg;

  // Store geometry.
  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int FREQ_W      = 16;
  localparam int ENTRY_W     = FREQ_W + 1;
  localparam int INDEX_W     = 8;
  localparam int COUNT_OUT_W = 9;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Stream payload widths.
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 48;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_NOTE_ON_TICKS = 2'd0,
    REG_GAP_TICKS     = 2'd1,
    REG_PAUSE_TICKS   = 2'd2
  } reg_idx_e;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_ADD_NOTE  = 3'd0,
    CMD_ADD_PAUSE = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_PLAY      = 3'd4,
    CMD_TICK      = 3'd5,
    CMD_READ      = 3'd6
  } cmd_e;

  // Playback phases.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TONE  = 2'd1,
    PH_GAP   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_e;

  // Command sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } stage_e;

  // Current timing registers.
  typedef struct packed {
    logic [7:0]        note_on_ticks;
    logic [FREQ_W-1:0] gap_ticks;
    logic [FREQ_W-1:0] pause_ticks;
  } cfg_t;

  // Store access request: one write port and one read port.
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  // One result transaction.
  typedef struct packed {
    logic                   tone_on;
    logic [FREQ_W-1:0]      tone_freq;
    logic                   playing;
    logic                   play_done;
    logic [COUNT_OUT_W-1:0] note_count;
    logic                   is_full;
    logic                   store_empty;
    logic [FREQ_W-1:0]      read_freq;
    logic                   read_is_pause;
  } result_t;

  // A phase length of zero counts as one tick.
  function automatic logic [FREQ_W-1:0] at_least_one(input logic [FREQ_W-1:0] v);
    at_least_one = (v == '0) ? FREQ_W'(1) : v;
  endfunction

endpackage

### sv/nsp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module nsp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/nsp_cfg.sv
// APB-style register bank for the tick counts of the note sequence player.
// Depends on nsp_pkg.
module nsp_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [nsp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nsp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output nsp_pkg::cfg_t                     cfg_o
);
  import nsp_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_NOTE_ON_TICKS: cfg_d.note_on_ticks = pwdata[7:0];
        REG_GAP_TICKS:     cfg_d.gap_ticks     = pwdata[FREQ_W-1:0];
        REG_PAUSE_TICKS:   cfg_d.pause_ticks   = pwdata[FREQ_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.note_on_ticks <= 8'd100;
      cfg_q.gap_ticks     <= 16'd50;
      cfg_q.pause_ticks   <= 16'd250;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data mux.
  always_comb begin
    case (reg_idx)
      REG_NOTE_ON_TICKS: prdata = APB_DATA_W'(cfg_q.note_on_ticks);
      REG_GAP_TICKS:     prdata = APB_DATA_W'(cfg_q.gap_ticks);
      REG_PAUSE_TICKS:   prdata = APB_DATA_W'(cfg_q.pause_ticks);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sv/nsp_core.sv
// Command sequencer of the note sequence player: issues the store read for a
// command, then updates count, playback state and the result register.
// Depends on nsp_pkg.
module nsp_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  nsp_pkg::cfg_t                    cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       in_cmd_i,
  input  logic [nsp_pkg::FREQ_W-1:0]       in_freq_i,
  input  logic [nsp_pkg::INDEX_W-1:0]      in_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output nsp_pkg::result_t                 out_res_o,
  output nsp_pkg::mem_req_t                mem_req_o,
  input  logic [nsp_pkg::ENTRY_W-1:0]      mem_rdata_i
);
  import nsp_pkg::*;

  stage_e stage_q, stage_d;
  logic   accept, exec;

  // Latched command.
  logic [2:0]         cmd_q;
  logic [FREQ_W-1:0]  freq_q;
  logic [INDEX_W-1:0] idx_q;

  // Architectural state.
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  phase_e            phase_q, phase_d;
  logic [FREQ_W-1:0] timer_q, timer_d;
  logic [FREQ_W-1:0] cur_q, cur_d;

  // Result register.
  logic    out_valid_q;
  result_t res_q, res_d;

  // Helpers for the execute step.
  logic              busy, done, rpause;
  logic [FREQ_W-1:0] rfreq, tick_left;
  logic [CNT_W-1:0]  pos_next;
  logic              entry_pause;

  // Stage control: next state.
  always_comb begin
    stage_d = stage_q;
    case (stage_q)
      ST_IDLE: if (in_valid_i) stage_d = ST_EXEC;
      ST_EXEC: if (!out_valid_q || out_ready_i) stage_d = ST_IDLE;
      default: stage_d = ST_IDLE;
    endcase
  end

  // Stage control: outputs.
  always_comb begin
    in_ready_o = 1'b0;
    exec       = 1'b0;
    case (stage_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: exec = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  assign pos_next = pos_q + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_cmd_i;
      freq_q <= in_freq_i;
      idx_q  <= in_index_i;
    end
  end

  // Execute step: update state from the command and the entry read.
  assign busy        = (phase_q != PH_IDLE);
  assign entry_pause = mem_rdata_i[FREQ_W];
  assign tick_left   = (timer_q != '0) ? timer_q - FREQ_W'(1) : '0;

  always_comb begin
    count_d         = count_q;
    pos_d           = pos_q;
    phase_d         = phase_q;
    timer_d         = timer_q;
    cur_d           = cur_q;
    done            = 1'b0;
    rfreq           = '0;
    rpause          = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = count_q[ADDR_W-1:0];
    mem_req_o.wdata = '0;

    // Store read issued with the accepted command.
    mem_req_o.re    = accept;
    mem_req_o.raddr = '0;
    case (cmd_e'(in_cmd_i))
      CMD_TICK: mem_req_o.raddr = pos_next[ADDR_W-1:0];
      CMD_READ: mem_req_o.raddr = ADDR_W'(in_index_i);
      default:  mem_req_o.raddr = '0;
    endcase

    if (exec) begin
      case (cmd_e'(cmd_q))
        CMD_ADD_NOTE: begin
          if (freq_q != '0 && !busy && count_q < CNT_W'(MAX_ENTRIES)) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = {1'b0, freq_q};
            count_d         = count_q + CNT_W'(1);
          end
        end
        CMD_ADD_PAUSE: begin
          if (!busy && count_q < CNT_W'(MAX_ENTRIES)) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = {1'b1, {FREQ_W{1'b0}}};
            count_d         = count_q + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (!busy && count_q != '0) count_d = count_q - CNT_W'(1);
        end
        CMD_CLEAR: begin
          if (!busy) count_d = '0;
        end
        CMD_PLAY: begin
          if (!busy && count_q != '0) begin
            pos_d = '0;
            if (entry_pause) begin
              phase_d = PH_PAUSE;
              timer_d = at_least_one(cfg_i.pause_ticks);
              cur_d   = '0;
            end else begin
              phase_d = PH_TONE;
              timer_d = at_least_one({8'd0, cfg_i.note_on_ticks});
              cur_d   = mem_rdata_i[FREQ_W-1:0];
            end
          end
        end
        CMD_TICK: begin
          if (busy) begin
            if (tick_left != '0) begin
              timer_d = tick_left;
            end else if (phase_q == PH_TONE) begin
              phase_d = PH_GAP;
              timer_d = at_least_one(cfg_i.gap_ticks);
            end else if (pos_next >= count_q) begin
              // Last entry finished: playback ends.
              phase_d = PH_IDLE;
              timer_d = '0;
              cur_d   = '0;
              pos_d   = '0;
              done    = 1'b1;
            end else begin
              pos_d = pos_next;
              if (entry_pause) begin
                phase_d = PH_PAUSE;
                timer_d = at_least_one(cfg_i.pause_ticks);
                cur_d   = '0;
              end else begin
                phase_d = PH_TONE;
                timer_d = at_least_one({8'd0, cfg_i.note_on_ticks});
                cur_d   = mem_rdata_i[FREQ_W-1:0];
              end
            end
          end
        end
        CMD_READ: begin
          if ({{CNT_W{1'b0}}, idx_q} < {{INDEX_W{1'b0}}, count_q}) begin
            if (entry_pause) rpause = 1'b1;
            else             rfreq  = mem_rdata_i[FREQ_W-1:0];
          end
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Result fields from the updated state.
  always_comb begin
    res_d.tone_on       = (phase_d == PH_TONE);
    res_d.tone_freq     = (phase_d == PH_TONE) ? cur_d : '0;
    res_d.playing       = (phase_d != PH_IDLE);
    res_d.play_done     = done;
    res_d.note_count    = COUNT_OUT_W'(count_d);
    res_d.is_full       = (count_d == CNT_W'(MAX_ENTRIES));
    res_d.store_empty   = (count_d == '0);
    res_d.read_freq     = rfreq;
    res_d.read_is_pause = rpause;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stage_q <= stage_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      timer_q <= timer_d;
      cur_q   <= cur_d;
      if (exec)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (exec) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

### sv/note_sequence_player_top.sv
// Top level of the note sequence player: stream ports, APB register port,
// entry store and command sequencer. Depends on nsp_pkg, nsp_ram, nsp_cfg, nsp_core.

// The block stores up to 256 tone or pause entries in a 256 x 17 synchronous
// RAM and plays them back one tick command at a time. Each command is accepted
// in ST_IDLE, which issues the RAM read of the entry it needs (slot 0 for play,
// the next slot for tick, the addressed slot for read); ST_EXEC then does the
// state update, which loads the result register. A new command is accepted
// while the previous result waits in the output register; the sequencer holds
// its update until that register is free. Every command yields exactly one
// result transaction with the playback and store status. No clearing pass is
// needed after reset: only slots below the entry count are ever used.
module note_sequence_player_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Command stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata: note_freq [15:0], entry_index [23:16].
  input  logic [nsp_pkg::S_TDATA_W-1:0]     s_tdata,
  // tuser: cmd [2:0].
  input  logic [nsp_pkg::S_TUSER_W-1:0]     s_tuser,
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata: tone_on [0], tone_freq [16:1], playing [17], play_done [18],
  // note_count [27:19], is_full [28], store_empty [29], read_freq [45:30],
  // read_is_pause [46], zero [47].
  output logic [nsp_pkg::M_TDATA_W-1:0]     m_tdata,
  // Register port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [nsp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nsp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import nsp_pkg::*;

  cfg_t               cfg;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  result_t            res;

  nsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  nsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_cmd_i    (s_tuser),
    .in_freq_i   (s_tdata[15:0]),
    .in_index_i  (s_tdata[23:16]),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_res_o   (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {1'b0, res.read_is_pause, res.read_freq, res.store_empty, res.is_full,
                    res.note_count, res.play_done, res.playing, res.tone_freq,
                    res.tone_on};

endmodule
